@@ rtl/sp_adj_pkg.sv @@
// Shared types and constants for the shortest path block over an adjacency matrix.
// Used by sp_adj_unit and shortest_paths_adjacency_matrix; depends on nothing else.
`timescale 1ns / 1ps

package sp_adj_pkg;

    localparam int NUM_VERTICES_DEF = 64;
    localparam int WEIGHT_BITS_DEF  = 16;

    localparam int VERTEX_BITS  = 6;
    localparam int WEIGHT_IN_BITS = 16;
    localparam int DIST_BITS    = 22;

    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_EDGE  = 2'd1,
        OP_RUN   = 2'd2
    } t_opcode;

endpackage

@@ rtl/sp_adj_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used for the edge matrix and the per-vertex tables.
`timescale 1ns / 1ps

module sp_adj_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/sp_adj_unit.sv @@
// Shared add-saturate-compare unit: sum = sat(base + addend), less = sum < bound.
// Depends on sp_adj_pkg for the distance width and its saturation value.
`timescale 1ns / 1ps

module sp_adj_unit #(
    parameter int WEIGHT_BITS = sp_adj_pkg::WEIGHT_BITS_DEF
) (
    input  logic [sp_adj_pkg::DIST_BITS-1:0] i_base,
    input  logic [WEIGHT_BITS-1:0]           i_addend,
    input  logic [sp_adj_pkg::DIST_BITS-1:0] i_bound,
    output logic [sp_adj_pkg::DIST_BITS-1:0] o_sum,
    output logic                             o_less
);

    localparam int DW = sp_adj_pkg::DIST_BITS;
    localparam int SW = ((DW > WEIGHT_BITS) ? DW : WEIGHT_BITS) + 1;

    logic [SW-1:0] full_sum;

    assign full_sum = SW'(i_base) + SW'(i_addend);
    assign o_sum    = (full_sum > SW'(sp_adj_pkg::DIST_MAX)) ? sp_adj_pkg::DIST_MAX
                                                             : full_sum[DW-1:0];
    assign o_less   = (o_sum < i_bound);

endmodule

@@ rtl/shortest_paths_adjacency_matrix.sv @@
// Single-source shortest paths over an undirected weighted graph kept in an adjacency
// matrix RAM. An edge write stores both directions one after the other through the single
// write port (states IDLE and EDGE2). Clearing the graph, and the pass that follows reset,
// sweep the matrix one entry a cycle with the input stalled. A run takes a setup state (INIT),
// then alternates a minimum scan and a relaxation sweep over all vertices, both driven
// through one shared add/compare unit, until no reachable vertex is left unsettled.
// Results then leave in vertex order through the read, load and send states, held while
// the receiver stalls.
`timescale 1ns / 1ps

module shortest_paths_adjacency_matrix #(
    parameter int NUM_VERTICES = sp_adj_pkg::NUM_VERTICES_DEF,
    parameter int WEIGHT_BITS  = sp_adj_pkg::WEIGHT_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [1:0]                            i_opcode,
    input  logic [sp_adj_pkg::VERTEX_BITS-1:0]    i_vertex_a,
    input  logic [sp_adj_pkg::VERTEX_BITS-1:0]    i_vertex_b,
    input  logic [sp_adj_pkg::WEIGHT_IN_BITS-1:0] i_edge_weight,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [sp_adj_pkg::VERTEX_BITS-1:0]    o_vertex,
    output logic [sp_adj_pkg::DIST_BITS-1:0]      o_distance,
    output logic [sp_adj_pkg::VERTEX_BITS-1:0]    o_predecessor,
    output logic                                  o_reachable,
    output logic                                  o_last
);

    localparam int VB     = sp_adj_pkg::VERTEX_BITS;
    localparam int DW     = sp_adj_pkg::DIST_BITS;
    localparam int VW     = $clog2(NUM_VERTICES);
    localparam int EDEPTH = NUM_VERTICES * NUM_VERTICES;
    localparam int EW     = $clog2(EDEPTH);
    localparam int EDW    = WEIGHT_BITS + 1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EDGE2,
        S_INIT,
        S_SCAN,
        S_RELAX,
        S_OUT_RD,
        S_OUT_LOAD,
        S_OUT_SEND
    } t_state;

    function automatic logic [EW-1:0] f_addr(input logic [VW-1:0] row,
                                             input logic [VW-1:0] col);
        return EW'(row) * EW'(NUM_VERTICES) + EW'(col);
    endfunction

    // Registers and next values.
    t_state                   r_state,    n_state;
    logic [EW-1:0]            r_clr_addr, n_clr_addr;
    logic [VW-1:0]            r_a,        n_a;
    logic [VW-1:0]            r_b,        n_b;
    logic [WEIGHT_BITS-1:0]   r_w,        n_w;
    logic [VW-1:0]            r_src,      n_src;
    logic                     r_src_ok,   n_src_ok;
    logic [NUM_VERTICES-1:0]  r_known,    n_known;
    logic [NUM_VERTICES-1:0]  r_settled,  n_settled;
    logic [VW-1:0]            r_idx,      n_idx;
    logic                     r_issue_done, n_issue_done;
    logic                     r_cmp_vld,  n_cmp_vld;
    logic [VW-1:0]            r_cmp_idx,  n_cmp_idx;
    logic                     r_found,    n_found;
    logic [VW-1:0]            r_pick,     n_pick;
    logic [DW-1:0]            r_best,     n_best;
    logic                     r_o_valid,  n_o_valid;
    logic [VB-1:0]            r_o_vertex, n_o_vertex;
    logic [DW-1:0]            r_o_dist,   n_o_dist;
    logic [VB-1:0]            r_o_pred,   n_o_pred;
    logic                     r_o_reach,  n_o_reach;
    logic                     r_o_last,   n_o_last;

    // Memory ports.
    logic                     e_we;
    logic [EW-1:0]            e_waddr;
    logic [EDW-1:0]           e_wdata;
    logic [EW-1:0]            e_raddr;
    logic [EDW-1:0]           e_rdata;
    logic                     d_we;
    logic [VW-1:0]            d_waddr;
    logic [DW-1:0]            d_wdata;
    logic [DW-1:0]            d_rdata;
    logic [VW-1:0]            p_wdata;
    logic [VW-1:0]            p_rdata;

    // Shared unit.
    logic [DW-1:0]            u_base;
    logic [WEIGHT_BITS-1:0]   u_add;
    logic [DW-1:0]            u_bound;
    logic [DW-1:0]            u_sum;
    logic                     u_less;

    logic                     a_ok;
    logic                     b_ok;
    logic                     idx_last;
    logic                     cmp_last;
    logic                     cand;
    logic                     edge_here;

    sp_adj_ram #(.WIDTH(EDW), .DEPTH(EDEPTH)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    sp_adj_ram #(.WIDTH(DW), .DEPTH(NUM_VERTICES)) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_raddr (r_idx),
        .o_rdata (d_rdata)
    );

    sp_adj_ram #(.WIDTH(VW), .DEPTH(NUM_VERTICES)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (p_wdata),
        .i_raddr (r_idx),
        .o_rdata (p_rdata)
    );

    sp_adj_unit #(.WEIGHT_BITS(WEIGHT_BITS)) u_unit (
        .i_base   (u_base),
        .i_addend (u_add),
        .i_bound  (u_bound),
        .o_sum    (u_sum),
        .o_less   (u_less)
    );

    // The scan compares a stored distance against the best so far; the relaxation
    // compares the settled distance plus the edge weight against the stored one.
    assign u_base  = (r_state == S_RELAX) ? r_best : d_rdata;
    assign u_add   = (r_state == S_RELAX) ? e_rdata[WEIGHT_BITS-1:0] : '0;
    assign u_bound = (r_state == S_RELAX) ? d_rdata : r_best;

    assign e_raddr   = f_addr(r_pick, r_idx);
    assign a_ok      = ({1'b0, i_vertex_a} < (VB + 1)'(NUM_VERTICES));
    assign b_ok      = ({1'b0, i_vertex_b} < (VB + 1)'(NUM_VERTICES));
    assign idx_last  = (r_idx == VW'(NUM_VERTICES - 1));
    assign cmp_last  = (r_cmp_idx == VW'(NUM_VERTICES - 1));
    assign cand      = r_known[r_cmp_idx] & ~r_settled[r_cmp_idx];
    assign edge_here = e_rdata[WEIGHT_BITS];
    assign p_wdata   = (r_state == S_INIT) ? r_src : r_pick;

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_vertex      = r_o_vertex;
    assign o_distance    = r_o_dist;
    assign o_predecessor = r_o_pred;
    assign o_reachable   = r_o_reach;
    assign o_last        = r_o_last;

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_a          = r_a;
        n_b          = r_b;
        n_w          = r_w;
        n_src        = r_src;
        n_src_ok     = r_src_ok;
        n_known      = r_known;
        n_settled    = r_settled;
        n_idx        = r_idx;
        n_issue_done = r_issue_done;
        n_cmp_vld    = r_cmp_vld;
        n_cmp_idx    = r_cmp_idx;
        n_found      = r_found;
        n_pick       = r_pick;
        n_best       = r_best;
        n_o_valid    = r_o_valid;
        n_o_vertex   = r_o_vertex;
        n_o_dist     = r_o_dist;
        n_o_pred     = r_o_pred;
        n_o_reach    = r_o_reach;
        n_o_last     = r_o_last;
        e_we         = 1'b0;
        e_waddr      = r_clr_addr;
        e_wdata      = '0;
        d_we         = 1'b0;
        d_waddr      = r_cmp_idx;
        d_wdata      = u_sum;

        unique case (r_state)
            S_CLEAR: begin
                e_we = 1'b1;
                if (r_clr_addr == EW'(EDEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    unique case (sp_adj_pkg::t_opcode'(i_opcode))
                        sp_adj_pkg::OP_CLEAR: begin
                            n_clr_addr = '0;
                            n_state    = S_CLEAR;
                        end
                        sp_adj_pkg::OP_EDGE: begin
                            // Out-of-range endpoints drop the transfer.
                            if (a_ok && b_ok) begin
                                e_we    = 1'b1;
                                e_waddr = f_addr(i_vertex_a[VW-1:0], i_vertex_b[VW-1:0]);
                                e_wdata = {1'b1, WEIGHT_BITS'(i_edge_weight)};
                                n_a     = i_vertex_a[VW-1:0];
                                n_b     = i_vertex_b[VW-1:0];
                                n_w     = WEIGHT_BITS'(i_edge_weight);
                                n_state = S_EDGE2;
                            end
                        end
                        sp_adj_pkg::OP_RUN: begin
                            n_src    = i_vertex_a[VW-1:0];
                            n_src_ok = a_ok;
                            n_state  = S_INIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_EDGE2: begin
                e_we    = 1'b1;
                e_waddr = f_addr(r_b, r_a);
                e_wdata = {1'b1, r_w};
                n_state = S_IDLE;
            end
            S_INIT: begin
                d_we      = r_src_ok;
                d_waddr   = r_src;
                d_wdata   = '0;
                n_known   = '0;
                n_known[r_src] = r_src_ok;
                n_settled = '0;
                n_idx        = '0;
                n_issue_done = 1'b0;
                n_cmp_vld    = 1'b0;
                n_found      = 1'b0;
                n_state      = r_src_ok ? S_SCAN : S_OUT_RD;
            end
            S_SCAN: begin
                // Reads are issued one vertex ahead of the compare.
                n_cmp_vld = ~r_issue_done;
                n_cmp_idx = r_idx;
                if (!r_issue_done) begin
                    if (idx_last) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                if (r_cmp_vld) begin
                    if (cand && (!r_found || u_less)) begin
                        n_found = 1'b1;
                        n_pick  = r_cmp_idx;
                        n_best  = d_rdata;
                    end
                    if (cmp_last) begin
                        n_idx        = '0;
                        n_issue_done = 1'b0;
                        n_cmp_vld    = 1'b0;
                        if (n_found) begin
                            n_settled[n_pick] = 1'b1;
                            n_state = S_RELAX;
                        end else begin
                            n_state = S_OUT_RD;
                        end
                    end
                end
            end
            S_RELAX: begin
                n_cmp_vld = ~r_issue_done;
                n_cmp_idx = r_idx;
                if (!r_issue_done) begin
                    if (idx_last) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                if (r_cmp_vld) begin
                    // Update only on a strictly shorter path, or a first one.
                    if (edge_here && !r_settled[r_cmp_idx] &&
                        (!r_known[r_cmp_idx] || u_less)) begin
                        d_we = 1'b1;
                        n_known[r_cmp_idx] = 1'b1;
                    end
                    if (cmp_last) begin
                        n_idx        = '0;
                        n_issue_done = 1'b0;
                        n_cmp_vld    = 1'b0;
                        n_found      = 1'b0;
                        n_state      = S_SCAN;
                    end
                end
            end
            S_OUT_RD: begin
                n_state = S_OUT_LOAD;
            end
            S_OUT_LOAD: begin
                n_o_valid  = 1'b1;
                n_o_vertex = VB'(r_idx);
                n_o_reach  = r_known[r_idx];
                n_o_dist   = r_known[r_idx] ? d_rdata : sp_adj_pkg::DIST_MAX;
                n_o_pred   = r_known[r_idx] ? VB'(p_rdata) : '0;
                n_o_last   = idx_last;
                n_state    = S_OUT_SEND;
            end
            S_OUT_SEND: begin
                if (!i_stall) begin
                    n_o_valid = 1'b0;
                    if (r_o_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_known      <= '0;
            r_settled    <= '0;
            r_idx        <= '0;
            r_issue_done <= 1'b0;
            r_cmp_vld    <= 1'b0;
            r_found      <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_known      <= n_known;
            r_settled    <= n_settled;
            r_idx        <= n_idx;
            r_issue_done <= n_issue_done;
            r_cmp_vld    <= n_cmp_vld;
            r_found      <= n_found;
            r_o_valid    <= n_o_valid;
            r_a          <= n_a;
            r_b          <= n_b;
            r_w          <= n_w;
            r_src        <= n_src;
            r_src_ok     <= n_src_ok;
            r_cmp_idx    <= n_cmp_idx;
            r_pick       <= n_pick;
            r_best       <= n_best;
            r_o_vertex   <= n_o_vertex;
            r_o_dist     <= n_o_dist;
            r_o_pred     <= n_o_pred;
            r_o_reach    <= n_o_reach;
            r_o_last     <= n_o_last;
        end
    end

endmodule
